>>> hw/rtl/orlc_pkg.sv
package orlc_pkg;

  // Index fields are sized for the largest supported row of cells
  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_RECORD = 2'd1,
    REQ_INVAL  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_AGE,
    WR_REG_AGE,
    WR_FILL,
    WR_INVAL,
    WR_CLEAR
  } wr_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic signed [31:0] frame_offset;
    logic [5:0]         reg_number;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] found_reg;
  } out_word_t;

  // Search word handed from cell to cell
  typedef struct packed {
    logic [31:0]      key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [5:0]       hit_reg;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      min_age;
    logic [IDX_W-1:0] min_idx;
  } scan_t;

  // Update broadcast to every cell
  typedef struct packed {
    wr_op_t           op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      offset;
    logic [5:0]       reg_number;
    logic [31:0]      age;
  } wr_t;

endpackage

>>> hw/rtl/orlc_cell.sv
module orlc_cell #(
  parameter int CELL_IDX = 0,
  parameter int REG_BITS = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  orlc_pkg::scan_t scan_i,
  input  orlc_pkg::wr_t   wr_i,
  output orlc_pkg::scan_t scan_o
);

  logic                valid_r;
  logic [31:0]         offset_r;
  logic [REG_BITS-1:0] reg_r;
  logic [31:0]         age_r;
  orlc_pkg::scan_t     scan_r;
  orlc_pkg::scan_t     scan_nxt;
  logic                sel;
  logic [REG_BITS-1:0] reg_in;

  localparam logic [orlc_pkg::IDX_W-1:0] MY_IDX = orlc_pkg::IDX_W'(CELL_IDX);

  assign sel    = (wr_i.idx == MY_IDX);
  assign reg_in = REG_BITS'(wr_i.reg_number);

  always_comb begin
    scan_nxt = scan_i;
    // first valid match wins
    if (valid_r && !scan_i.hit && (offset_r == scan_i.key)) begin
      scan_nxt.hit     = 1'b1;
      scan_nxt.hit_idx = MY_IDX;
      scan_nxt.hit_reg = 6'(reg_r);
    end
    if (!valid_r && !scan_i.free_found) begin
      scan_nxt.free_found = 1'b1;
      scan_nxt.free_idx   = MY_IDX;
    end
    // strict compare keeps the first entry on ties
    if (valid_r && (age_r < scan_i.min_age)) begin
      scan_nxt.min_age = age_r;
      scan_nxt.min_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
  end

  assign scan_o = scan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (wr_i.op)
        orlc_pkg::WR_FILL: begin
          if (sel) valid_r <= 1'b1;
        end
        orlc_pkg::WR_INVAL: begin
          if (valid_r && (reg_r == reg_in)) valid_r <= 1'b0;
        end
        orlc_pkg::WR_CLEAR: valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (wr_i.op)
      orlc_pkg::WR_AGE: begin
        if (sel) age_r <= wr_i.age;
      end
      orlc_pkg::WR_REG_AGE: begin
        if (sel) begin
          reg_r <= reg_in;
          age_r <= wr_i.age;
        end
      end
      orlc_pkg::WR_FILL: begin
        if (sel) begin
          offset_r <= wr_i.offset;
          reg_r    <= reg_in;
          age_r    <= wr_i.age;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/offset_register_lru_cache_top.sv
// Offset-to-register LRU cache built as a row of ENTRIES cells.
// Lookup/record while enabled: the search word steps one cell per cycle down the
// row of registered cells; busy stays high until the scan is done, then out_valid is registered.
// Invalidate, clear and disabled requests: result in the cycle after start, busy stays low.
// Synchronous active-low reset clears valid bits, counter and enable; no
// clearing pass. Results are strobed for one cycle; the receiver cannot stall.
module offset_register_lru_cache_top #(
  parameter int ENTRIES  = 8,
  parameter int REG_BITS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  orlc_pkg::in_word_t  in_word,
  output logic                out_valid,
  output orlc_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  orlc_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  orlc_pkg::in_word_t  req_r;
  logic                enable_r;
  logic [31:0]         counter_r, counter_nxt;
  logic                out_valid_r, out_valid_nxt;
  orlc_pkg::out_word_t out_word_r, out_word_nxt;
  orlc_pkg::wr_t       wr;
  orlc_pkg::scan_t     chain [ENTRIES+1];
  orlc_pkg::scan_t     tail;
  logic                accept;
  logic                scan_done;

  assign busy      = (state_r != orlc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // seed the search word from the held request
  always_comb begin
    chain[0].key        = 32'(req_r.frame_offset);
    chain[0].hit        = 1'b0;
    chain[0].hit_idx    = '0;
    chain[0].hit_reg    = '0;
    chain[0].free_found = 1'b0;
    chain[0].free_idx   = '0;
    chain[0].min_age    = '1;
    chain[0].min_idx    = '0;
  end

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    orlc_cell #(
      .CELL_IDX (gi),
      .REG_BITS (REG_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .scan_i (chain[gi]),
      .wr_i   (wr),
      .scan_o (chain[gi+1])
    );
  end

  assign tail      = chain[ENTRIES];
  assign scan_done = (state_r == orlc_pkg::ST_SCAN) && (cnt_r == CNT_W'(ENTRIES));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    counter_nxt    = counter_r;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    wr.op          = orlc_pkg::WR_NONE;
    wr.idx         = '0;
    wr.offset      = 32'(req_r.frame_offset);
    wr.reg_number  = req_r.reg_number;
    wr.age         = counter_r;

    unique case (state_r)
      orlc_pkg::ST_IDLE: begin
        if (accept) begin
          out_word_nxt = '0;
          case (in_word.req_type) inside
            orlc_pkg::REQ_LOOKUP, orlc_pkg::REQ_RECORD: begin
              if (enable_r) begin
                counter_nxt = counter_r + 32'd1;
                cnt_nxt     = '0;
                state_nxt   = orlc_pkg::ST_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            orlc_pkg::REQ_INVAL: begin
              wr.op         = orlc_pkg::WR_INVAL;
              wr.reg_number = in_word.reg_number;
              out_valid_nxt = 1'b1;
            end
            default: begin
              wr.op         = orlc_pkg::WR_CLEAR;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      orlc_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt     = orlc_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          if (req_r.req_type == orlc_pkg::REQ_LOOKUP) begin
            if (tail.hit) begin
              out_word_nxt.hit       = 1'b1;
              out_word_nxt.found_reg = tail.hit_reg;
              wr.op                  = orlc_pkg::WR_AGE;
              wr.idx                 = tail.hit_idx;
            end
          end else if (tail.hit) begin
            wr.op  = orlc_pkg::WR_REG_AGE;
            wr.idx = tail.hit_idx;
          end else begin
            wr.op  = orlc_pkg::WR_FILL;
            wr.idx = tail.free_found ? tail.free_idx : tail.min_idx;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = orlc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= orlc_pkg::ST_IDLE;
      cnt_r       <= '0;
      enable_r    <= 1'b0;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      counter_r   <= counter_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) enable_r <= cfg_data;
    end
  end

  // hold the request and result word
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_word;
    out_word_r <= out_word_nxt;
  end

  a_out_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(rst_n && (accept || scan_done)))
    else $error("result strobe without an accepted word or finished scan");

  a_counter_on_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (counter_r != $past(counter_r))) |-> $past(accept && enable_r))
    else $error("access counter moved without an enabled request");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == orlc_pkg::ST_SCAN) |-> (cnt_r <= CNT_W'(ENTRIES)))
    else $error("scan counter ran past the row of cells");

  a_hit_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.hit) |-> $past(scan_done))
    else $error("hit reported without a completed scan");

endmodule

>>> test/orlc_cache_checker.sv
module orlc_cache_checker
  import orlc_pkg::*;
#(
  parameter int ENTRIES  = 8,
  parameter int REG_BITS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        fail_count,
  output int        words_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic                line_valid [ENTRIES];
  logic [31:0]         line_offset[ENTRIES];
  logic [REG_BITS-1:0] line_reg   [ENTRIES];
  logic [31:0]         line_age   [ENTRIES];
  logic [31:0]         touch_count;
  logic                cache_on;
  out_word_t           expected_words[$];
  out_word_t           want;
  int                  mismatches;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    mismatches    = 0;
    cache_on      = 1'b0;
    touch_count   = '0;
    for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
  end

  // Update the cache image for one request and return the word it should produce
  function automatic out_word_t apply_request(in_word_t w);
    int                  slot;
    int                  victim;
    out_word_t           r;
    logic [REG_BITS-1:0] rn;
    r      = '0;
    rn     = w.reg_number[REG_BITS-1:0];
    slot   = -1;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && line_valid[i] && line_offset[i] == w.frame_offset) slot = i;
    end
    case (w.req_type)
      REQ_LOOKUP: begin
        if (cache_on) begin
          touch_count = touch_count + 32'd1;
          if (slot >= 0) begin
            r.hit           = 1'b1;
            r.found_reg     = 6'(line_reg[slot]);
            line_age[slot]  = touch_count;
          end
        end
      end
      REQ_RECORD: begin
        if (cache_on) begin
          touch_count = touch_count + 32'd1;
          if (slot < 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (victim < 0 && !line_valid[i]) victim = i;
            end
            // full: oldest stamp wins, lowest index on ties
            if (victim < 0) begin
              victim = 0;
              for (int i = 1; i < ENTRIES; i++) begin
                if (line_age[i] < line_age[victim]) victim = i;
              end
            end
            slot               = victim;
            line_valid[slot]   = 1'b1;
            line_offset[slot]  = w.frame_offset;
          end
          line_reg[slot] = rn;
          line_age[slot] = touch_count;
        end
      end
      REQ_INVAL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && line_reg[i] == rn) line_valid[i] = 1'b0;
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
      touch_count = '0;
      cache_on    = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) cache_on = cfg_data;
      // drain the result before taking a new word; both can land on one edge
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: hit=%0b found_reg=%0d",
                     out_word.hit, out_word.found_reg);
        end else begin
          want = expected_words.pop_front();
          if (want.hit !== out_word.hit || want.found_reg !== out_word.found_reg) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected hit=%0b found_reg=%0d, got hit=%0b found_reg=%0d",
                       want.hit, want.found_reg, out_word.hit, out_word.found_reg);
          end
        end
      end
      if (start && !busy) expected_words.push_back(apply_request(in_word));
    end
    fail_count    <= mismatches;
    words_pending <= expected_words.size();
  end

endmodule

>>> test/offset_register_lru_cache_top_tb.sv
module offset_register_lru_cache_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import orlc_pkg::*;

  localparam int ENTRIES     = 8;
  localparam int REG_BITS    = 6;
  localparam int POOL        = 12;
  localparam int STALL_LIMIT = 2000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_word_t  in_word   = '0;
  logic      out_valid;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  int          fail_count;
  int          words_pending;
  int          quiet_cycles = 0;
  logic [31:0] key_pool[POOL];

  always #6 clk = ~clk;

  offset_register_lru_cache_top #(
    .ENTRIES (ENTRIES),
    .REG_BITS(REG_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  orlc_cache_checker #(
    .ENTRIES (ENTRIES),
    .REG_BITS(REG_BITS)
  ) cache_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_word     (out_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  // Stop a hung run: count cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t make_word(req_type_t kind, logic [31:0] key, logic [5:0] rn);
    in_word_t w;
    w.req_type     = kind;
    w.frame_offset = key;
    w.reg_number   = rn;
    return w;
  endfunction

  // Mostly pooled keys and a few low registers, so hits, updates,
  // evictions and invalidations keep happening
  function automatic in_word_t random_request();
    int       pick;
    in_word_t w;
    pick = $urandom_range(99);
    if (pick < 45) w.req_type = REQ_LOOKUP;
    else if (pick < 80) w.req_type = REQ_RECORD;
    else if (pick < 96) w.req_type = REQ_INVAL;
    else w.req_type = REQ_CLEAR;
    if ($urandom_range(9) == 0) w.frame_offset = $urandom;
    else w.frame_offset = key_pool[$urandom_range(POOL-1)];
    if ($urandom_range(3) == 0) w.reg_number = 6'($urandom_range(63));
    else w.reg_number = 6'($urandom_range(7));
    return w;
  endfunction

  task automatic push_request(input in_word_t w);
    in_word <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic write_enable(input logic en);
    cfg_data  <= en;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic en, input int idle_pct, input int count);
    wait_drained();
    repeat (ENTRIES + 2) @(posedge clk);
    write_enable(en);
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL; i++) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      // hold off midway until the cache has answered everything
      if (n == count / 2) wait_drained();
      while ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
      push_request(random_request());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled: lookup misses, record is dropped, invalidate and clear still answer
    push_request(make_word(REQ_LOOKUP, 32'h0000_0000, 6'd0));
    push_request(make_word(REQ_RECORD, 32'h0000_0000, 6'd5));
    push_request(make_word(REQ_INVAL, 32'h0000_0000, 6'd5));
    push_request(make_word(REQ_CLEAR, 32'h0000_0000, 6'd0));
    wait_drained();
    repeat (ENTRIES + 2) @(posedge clk);
    write_enable(1'b1);

    push_request(make_word(REQ_RECORD, 32'h8000_0000, 6'd63));
    push_request(make_word(REQ_RECORD, 32'h7fff_ffff, 6'd0));
    push_request(make_word(REQ_LOOKUP, 32'h8000_0000, 6'd0));
    push_request(make_word(REQ_LOOKUP, 32'h7fff_ffff, 6'd0));
    // record of a present key rewrites its register
    push_request(make_word(REQ_RECORD, 32'h7fff_ffff, 6'd21));
    push_request(make_word(REQ_LOOKUP, 32'h7fff_ffff, 6'd0));
    // fill the remaining free slots and record past them, two of the new keys sharing a register
    push_request(make_word(REQ_RECORD, 32'h0000_0000, 6'd9));
    push_request(make_word(REQ_RECORD, 32'hffff_ffff, 6'd9));
    for (int k = 2; k < ENTRIES; k++)
      push_request(make_word(REQ_RECORD, 32'(k), 6'(k + 40)));
    push_request(make_word(REQ_LOOKUP, 32'h8000_0000, 6'd0));
    // full cache: the least recently used entry gets replaced
    push_request(make_word(REQ_RECORD, 32'h0000_5555, 6'd7));
    push_request(make_word(REQ_LOOKUP, 32'h7fff_ffff, 6'd0));
    push_request(make_word(REQ_INVAL, 32'h0000_0000, 6'd9));
    push_request(make_word(REQ_LOOKUP, 32'h0000_0000, 6'd0));
    push_request(make_word(REQ_LOOKUP, 32'h0000_5555, 6'd0));
    push_request(make_word(REQ_CLEAR, 32'h0000_0000, 6'd0));
    push_request(make_word(REQ_LOOKUP, 32'h8000_0000, 6'd0));

    run_phase(1'b1, 0, 400);
    run_phase(1'b1, 78, 350);
    run_phase(1'b0, 30, 150);
    run_phase(1'b1, 30, 350);
    run_phase(1'b1, 0, 200);

    wait_drained();
    repeat (ENTRIES + 4) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
